[sv/tme_pkg.sv]
// shared constants for the touchpad mouse emulator
package tme_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] REG_ENABLE      = 2'd0;
  localparam logic [1:0] REG_SENSITIVITY = 2'd1;
  localparam logic [1:0] REG_HOLD_TIME   = 2'd2;
  localparam logic [1:0] REG_DRAG_DIST   = 2'd3;

  // register reset values
  localparam logic [11:0] SENS_RESET = 12'd256;
  localparam logic [15:0] HOLD_RESET = 16'd380;
  localparam logic [15:0] DRAG_RESET = 16'd400;

  // divide by 20 as multiply by ceil(2^24/20) and shift by 24
  localparam int          RECIP_SHIFT = 24;
  localparam logic [19:0] RECIP_20    = 20'd838861;

  // output saturation limits
  localparam int SAT_MAX = 32767;
  localparam int SAT_MIN = -32768;

  // squared delta at or below which the slow smoothing alpha applies
  localparam int SLOW_LIMIT = 100;

endpackage

[sv/touchpad_mouse_emulator.sv]
// touchpad mouse emulator top level: sequencer around one shared multiplier
//
// One touchpad sample in, one result word out while enable is set (none while it is
// clear). Every sample walks the same sequence: twelve multiply steps on one shared
// signed multiplier (squared deltas, squared press distance, smoothing, gain, motion,
// divide-by-20 for scroll), a bit-pair square root loop of COORD_BITS+FRAC_BITS+1
// steps and its exit, and a final commit. The square root loop is the longest part
// of that sequence. The input is stalled while a sample is at work; a finished
// result waits in the output register and the next sample is taken meanwhile, but
// the commit of that sample waits until the output register is free.
module touchpad_mouse_emulator #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // sample input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         finger0_down,
  input  logic                         finger1_down,
  input  logic [COORD_BITS-1:0]        touch_x,
  input  logic [COORD_BITS-1:0]        touch_y,
  input  logic                         click_down,
  input  logic [31:0]                  time_ms,
  // result output
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [15:0]           move_dx,
  output logic signed [15:0]           move_dy,
  output logic signed [15:0]           wheel,
  output logic                         left_press,
  output logic                         left_release,
  output logic                         right_press,
  output logic                         right_release
);
  import tme_pkg::*;

  localparam int CW  = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int DXW = CW + 1;
  localparam int SW  = CW + F + 1;
  localparam int WA  = CW + F + 2;
  localparam int GW  = F + 16;
  localparam int WB  = GW + 1;
  localparam int PW  = WA + WB;
  localparam int MW  = 2 * CW + 2;
  localparam int VW  = 2 * ((MW + 2 * F + 1) / 2);
  localparam int SQW = VW / 2;
  localparam int FW  = F + 2;
  localparam int AW  = CW + F + 8;
  localparam int STW = AW - F;
  localparam int SCW = CW + 4;
  localparam int TKW = CW + 1;
  localparam int WHW = CW + 8;

  localparam logic [FW-1:0] ONE_Q      = FW'(2 ** F);
  localparam logic [F:0]    ONE_A      = (F+1)'(2 ** F);
  localparam logic [F:0]    ALPHA_FAST = (F+1)'((3 << F) >> 2);
  localparam logic [F:0]    ALPHA_SLOW = (F+1)'((115 << F) >> 8);
  localparam logic [FW-1:0] EXTRA_CAP  = FW'(((16 << F) + 5) / 10);

  // sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_PREP  = 5'd1;
  localparam logic [4:0] S_M_DXX = 5'd2;
  localparam logic [4:0] S_M_DYY = 5'd3;
  localparam logic [4:0] S_M_EXX = 5'd4;
  localparam logic [4:0] S_M_EYY = 5'd5;
  localparam logic [4:0] S_M_AX  = 5'd6;
  localparam logic [4:0] S_M_BX  = 5'd7;
  localparam logic [4:0] S_M_AY  = 5'd8;
  localparam logic [4:0] S_M_BY  = 5'd9;
  localparam logic [4:0] S_SY    = 5'd10;
  localparam logic [4:0] S_SQRT  = 5'd11;
  localparam logic [4:0] S_M_G   = 5'd12;
  localparam logic [4:0] S_GAIN  = 5'd13;
  localparam logic [4:0] S_M_MX  = 5'd14;
  localparam logic [4:0] S_M_MY  = 5'd15;
  localparam logic [4:0] S_ACC   = 5'd16;
  localparam logic [4:0] S_FIN   = 5'd17;

  // truncate toward zero after a right shift
  function automatic logic signed [PW-1:0] tz(input logic signed [PW-1:0] v, input int n);
    logic [PW-1:0] m;
    m = v[PW-1] ? PW'(-v) : PW'(v);
    m = m >> n;
    tz = v[PW-1] ? -$signed(m) : $signed(m);
  endfunction

  // saturate to 16 bits signed
  function automatic logic signed [15:0] sat16(input logic signed [PW-1:0] v);
    if (v > PW'(SAT_MAX)) begin
      sat16 = 16'(SAT_MAX);
    end else if (v < PW'(SAT_MIN)) begin
      sat16 = 16'(SAT_MIN);
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  // configuration registers
  logic        enable;
  logic [11:0] sensitivity;
  logic [15:0] hold_time_ms;
  logic [15:0] drag_dist_sq;

  // block state
  logic                   was_touching;
  logic [CW-1:0]          last_x;
  logic [CW-1:0]          last_y;
  logic signed [SW-1:0]   smooth_dx;
  logic signed [SW-1:0]   smooth_dy;
  logic signed [F:0]      frac_acc_x;
  logic signed [F:0]      frac_acc_y;
  logic signed [SCW-1:0]  scroll_acc;
  logic                   button_held;
  logic [31:0]            press_time;
  logic [CW-1:0]          press_x;
  logic [CW-1:0]          press_y;
  logic                   holding_right;
  logic                   left_dragging;
  logic                   two_finger_click;

  // latched sample
  logic          smp_f0;
  logic          smp_f1;
  logic [CW-1:0] smp_x;
  logic [CW-1:0] smp_y;
  logic          smp_click;
  logic [31:0]   smp_time;

  // working registers
  logic [4:0]              state;
  logic signed [DXW-1:0]   dx;
  logic signed [DXW-1:0]   dy;
  logic [MW-1:0]           mag;
  logic [MW-1:0]           press_dsq;
  logic signed [PW-1:0]    prod;
  logic signed [PW-1:0]    ta;
  logic signed [SW-1:0]    nsx;
  logic signed [SW-1:0]    nsy;
  logic [VW-1:0]           sq_v;
  logic [VW-1:0]           sq_res;
  logic [VW-1:0]           sq_bit;
  logic [GW-1:0]           gain;
  logic signed [SCW-1:0]   ssum;
  logic [TKW-1:0]          tmag;
  logic signed [AW-1:0]    accx;
  logic signed [AW-1:0]    accy;

  // combinational helpers
  logic signed [WA-1:0]   mul_a;
  logic signed [WB-1:0]   mul_b;
  logic [F:0]             alpha;
  logic [SQW-5:0]         ext;
  logic [FW-1:0]          factor;
  logic [VW-1:0]          sq_trial;
  logic signed [DXW-1:0]  ex;
  logic signed [DXW-1:0]  ey;
  logic [SCW-1:0]         sabs;
  logic signed [STW-1:0]  stx;
  logic signed [STW-1:0]  sty;
  logic signed [AW-1:0]   resx;
  logic signed [AW-1:0]   resy;
  logic signed [TKW:0]    ticks;
  logic signed [WHW-1:0]  wheelv;
  logic signed [SCW-1:0]  sres;
  logic [31:0]            elapsed;
  logic                   out_free;

  // configuration read side
  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      REG_ENABLE:      prdata = {31'd0, enable};
      REG_SENSITIVITY: prdata = {20'd0, sensitivity};
      REG_HOLD_TIME:   prdata = {16'd0, hold_time_ms};
      REG_DRAG_DIST:   prdata = {16'd0, drag_dist_sq};
      default:         prdata = 32'd0;
    endcase
  end

  // configuration write side
  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b1;
      sensitivity  <= SENS_RESET;
      hold_time_ms <= HOLD_RESET;
      drag_dist_sq <= DRAG_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_ENABLE:      enable       <= pwdata[0];
        REG_SENSITIVITY: sensitivity  <= pwdata[11:0];
        REG_HOLD_TIME:   hold_time_ms <= pwdata[15:0];
        REG_DRAG_DIST:   drag_dist_sq <= pwdata[15:0];
        default:         enable       <= enable;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // helpers derived from working registers
  always_comb begin
    alpha    = (mag > MW'(SLOW_LIMIT)) ? ALPHA_FAST : ALPHA_SLOW;
    ext      = sq_res[SQW-1:4];
    factor   = ONE_Q + ((PW'(ext) > PW'(EXTRA_CAP)) ? EXTRA_CAP : FW'(ext));
    sq_trial = sq_res + sq_bit;
    ex       = $signed({1'b0, smp_x}) - $signed({1'b0, press_x});
    ey       = $signed({1'b0, smp_y}) - $signed({1'b0, press_y});
    sabs     = ssum[SCW-1] ? SCW'(-ssum) : SCW'(ssum);
    stx      = STW'(tz(PW'(accx), F));
    sty      = STW'(tz(PW'(accy), F));
    resx     = accx - (AW'(stx) <<< F);
    resy     = accy - (AW'(sty) <<< F);
    ticks    = ssum[SCW-1] ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
    wheelv   = (WHW'(ticks) <<< 5) - (WHW'(ticks) <<< 1);
    sres     = ssum - ((SCW'(ticks) <<< 4) + (SCW'(ticks) <<< 2));
    elapsed  = smp_time - press_time;
  end

  // shared multiplier operand select
  always_comb begin
    case (state)
      S_M_DXX: begin
        mul_a = WA'(dx);
        mul_b = WB'(dx);
      end
      S_M_DYY: begin
        mul_a = WA'(dy);
        mul_b = WB'(dy);
      end
      S_M_EXX: begin
        mul_a = WA'(ex);
        mul_b = WB'(ex);
      end
      S_M_EYY: begin
        mul_a = WA'(ey);
        mul_b = WB'(ey);
      end
      S_M_AX: begin
        mul_a = WA'(dx);
        mul_b = WB'($signed({1'b0, alpha}));
      end
      S_M_BX: begin
        mul_a = WA'(smooth_dx);
        mul_b = WB'($signed({1'b0, ONE_A - alpha}));
      end
      S_M_AY: begin
        mul_a = WA'(dy);
        mul_b = WB'($signed({1'b0, alpha}));
      end
      S_M_BY: begin
        mul_a = WA'(smooth_dy);
        mul_b = WB'($signed({1'b0, ONE_A - alpha}));
      end
      S_M_G: begin
        mul_a = WA'($signed({1'b0, sensitivity}));
        mul_b = WB'($signed({1'b0, factor}));
      end
      S_GAIN: begin
        mul_a = WA'($signed({1'b0, sabs}));
        mul_b = WB'($signed({1'b0, RECIP_20}));
      end
      S_M_MX: begin
        mul_a = WA'(nsx);
        mul_b = $signed({1'b0, gain});
      end
      S_M_MY: begin
        mul_a = WA'(nsy);
        mul_b = $signed({1'b0, gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      was_touching     <= 1'b0;
      last_x           <= '0;
      last_y           <= '0;
      smooth_dx        <= '0;
      smooth_dy        <= '0;
      frac_acc_x       <= '0;
      frac_acc_y       <= '0;
      scroll_acc       <= '0;
      button_held      <= 1'b0;
      press_time       <= '0;
      press_x          <= '0;
      press_y          <= '0;
      holding_right    <= 1'b0;
      left_dragging    <= 1'b0;
      two_finger_click <= 1'b0;
    end else begin
      // output word taken, unless a new one is committed in the same cycle
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            smp_f0    <= finger0_down;
            smp_f1    <= finger1_down;
            smp_x     <= touch_x;
            smp_y     <= touch_y;
            smp_click <= click_down;
            smp_time  <= time_ms;
            if (enable) begin
              state <= S_PREP;
            end
          end
        end
        // deltas, touch start and lift
        S_PREP: begin
          if (smp_f0) begin
            if (!was_touching) begin
              dx         <= '0;
              dy         <= '0;
              smooth_dx  <= '0;
              smooth_dy  <= '0;
              frac_acc_x <= '0;
              frac_acc_y <= '0;
              scroll_acc <= '0;
            end else begin
              dx <= $signed({1'b0, smp_x}) - $signed({1'b0, last_x});
              dy <= $signed({1'b0, smp_y}) - $signed({1'b0, last_y});
            end
            last_x       <= smp_x;
            last_y       <= smp_y;
            was_touching <= 1'b1;
          end else begin
            dx           <= '0;
            dy           <= '0;
            was_touching <= 1'b0;
            smooth_dx    <= '0;
            smooth_dy    <= '0;
            frac_acc_x   <= '0;
            frac_acc_y   <= '0;
            scroll_acc   <= '0;
          end
          state <= S_M_DXX;
        end
        S_M_DXX: begin
          ssum  <= scroll_acc - SCW'(SCW'(dy) * 7);
          state <= S_M_DYY;
        end
        S_M_DYY: begin
          mag   <= prod[MW-1:0];
          state <= S_M_EXX;
        end
        S_M_EXX: begin
          mag   <= mag + prod[MW-1:0];
          state <= S_M_EYY;
        end
        S_M_EYY: begin
          press_dsq <= prod[MW-1:0];
          state     <= S_M_AX;
        end
        S_M_AX: begin
          press_dsq <= press_dsq + prod[MW-1:0];
          state     <= S_M_BX;
        end
        // smoothing: alpha*d*one + (one-alpha)*s
        S_M_BX: begin
          ta    <= prod;
          state <= S_M_AY;
        end
        S_M_AY: begin
          nsx   <= SW'(tz((ta <<< F) + prod, F));
          state <= S_M_BY;
        end
        S_M_BY: begin
          ta    <= prod;
          state <= S_SY;
        end
        S_SY: begin
          nsy    <= SW'(tz((ta <<< F) + prod, F));
          sq_v   <= VW'(mag) << (2 * F);
          sq_res <= '0;
          sq_bit <= VW'(1) << (VW - 2);
          state  <= S_SQRT;
        end
        // square root, one bit pair per cycle
        S_SQRT: begin
          if (sq_bit != '0) begin
            if (sq_v >= sq_trial) begin
              sq_v   <= sq_v - sq_trial;
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end else begin
            state <= S_M_G;
          end
        end
        S_M_G: begin
          state <= S_GAIN;
        end
        S_GAIN: begin
          gain  <= prod[GW-1:0] + (prod[GW-1:0] << 1);
          state <= S_M_MX;
        end
        S_M_MX: begin
          tmag  <= prod[RECIP_SHIFT +: TKW];
          state <= S_M_MY;
        end
        S_M_MY: begin
          accx  <= AW'(tz(prod, F + 10)) + AW'(frac_acc_x);
          state <= S_ACC;
        end
        S_ACC: begin
          accy  <= AW'(tz(prod, F + 10)) + AW'(frac_acc_y);
          state <= S_FIN;
        end
        // commit state and build the result word
        S_FIN: begin
          if (out_free) begin
            move_dx       <= '0;
            move_dy       <= '0;
            wheel         <= '0;
            left_press    <= 1'b0;
            left_release  <= 1'b0;
            right_press   <= 1'b0;
            right_release <= 1'b0;
            // motion or scroll
            if (smp_f0) begin
              if (!smp_f1) begin
                if (mag != '0) begin
                  smooth_dx  <= nsx;
                  smooth_dy  <= nsy;
                  frac_acc_x <= resx[F:0];
                  frac_acc_y <= resy[F:0];
                  move_dx    <= sat16(PW'(stx));
                  move_dy    <= sat16(PW'(sty));
                end else begin
                  smooth_dx <= SW'(tz(PW'(smooth_dx), 1));
                  smooth_dy <= SW'(tz(PW'(smooth_dy), 1));
                end
              end else begin
                scroll_acc <= sres;
                wheel      <= sat16(PW'(wheelv));
              end
            end
            // click handling
            if (smp_click && !button_held) begin
              button_held      <= 1'b1;
              press_time       <= smp_time;
              press_x          <= smp_x;
              press_y          <= smp_y;
              holding_right    <= 1'b0;
              left_dragging    <= 1'b0;
              two_finger_click <= smp_f1;
              right_press      <= smp_f1;
            end else if (smp_click && button_held) begin
              if (!two_finger_click && !holding_right && !left_dragging) begin
                if (press_dsq > MW'(drag_dist_sq)) begin
                  left_dragging <= 1'b1;
                  left_press    <= 1'b1;
                end else if (elapsed >= 32'(hold_time_ms)) begin
                  holding_right <= 1'b1;
                  right_press   <= 1'b1;
                end
              end
            end else if (!smp_click && button_held) begin
              button_held <= 1'b0;
              if (two_finger_click) begin
                right_release    <= 1'b1;
                two_finger_click <= 1'b0;
              end else if (holding_right) begin
                right_release <= 1'b1;
                holding_right <= 1'b0;
              end else if (left_dragging) begin
                left_release  <= 1'b1;
                left_dragging <= 1'b0;
              end else begin
                left_press   <= 1'b1;
                left_release <= 1'b1;
              end
            end
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
